/* rtl/core/ecpo_pkg.sv */
`default_nettype none

package ecpo_pkg;

  // field width of the datapath (8 to 64)
  localparam int FIELD_BITS = 64;
  localparam int FW = FIELD_BITS;
  localparam int CW = $clog2(FW);

  typedef logic [FW-1:0] fe_t;

  // register reset values
  localparam logic [63:0] COEF_A_RST = 64'd0;
  localparam logic [63:0] COEF_B_RST = 64'd7;
  localparam logic [63:0] PRIME_RST  = 64'hFFFF_FFFF_FFFF_FFC5;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_COEF_A = 2'd0,
    CFG_COEF_B = 2'd1,
    CFG_PRIME  = 2'd2
  } cfg_idx_t;

  // operation modes, the unused code acts as the on-curve check
  localparam logic [1:0] MODE_MUL   = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // shared unit operations
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } unit_op_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] first_x;
    logic [63:0] first_y;
    logic        first_at_infinity;
    logic [63:0] second_x;
    logic [63:0] second_y;
    logic        second_at_infinity;
    logic [63:0] scalar;
  } item_t;

  typedef struct packed {
    logic [63:0] result_x;
    logic [63:0] result_y;
    logic        result_at_infinity;
    logic        on_curve;
    logic        curve_valid;
    logic        no_inverse;
  } result_t;

  // modular add of two reduced values
  function automatic fe_t m_add(fe_t x, fe_t y, fe_t p);
    logic [FW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[FW-1:0];
  endfunction

  // modular subtract of two reduced values
  function automatic fe_t m_sub(fe_t x, fe_t y, fe_t p);
    logic [FW:0] s;
    if (x >= y) s = {1'b0, x} - {1'b0, y};
    else s = {1'b0, x} + {1'b0, p} - {1'b0, y};
    return s[FW-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ec_prime_field_point_ops.sv */
`default_nettype none

// Affine elliptic-curve point unit over a prime field, y^2 = x^3 + a*x + b mod p, with
// a, b and p set through the configuration port, which the user must do only while the
// block is idle; the block itself does not enforce this. Each item does a scalar
// multiply k*P (right-to-left double-and-add), a point add P+Q (doubling when equal) or
// an on-curve test of P, and always reports whether 4a^3+27b^2 is nonzero mod p. One
// item is in work at a time; item_stall stays high until it is done, and a finished
// result sits in an output register so the next item can be taken meanwhile. All
// arithmetic runs through one shared modular unit; a multiply takes one multiplier bit
// per cycle, stopping early for a short multiplier, and division is an aligned long
// division. A point add forms its slope with an extended-Euclid inverse and modular
// multiplies; a scalar multiply does one doubling per scalar bit up to the top set bit
// plus one add per set bit, so up to 128 point operations.

module ec_prime_field_point_ops import ecpo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int NST = 45;

  typedef enum logic [NST-1:0] {
    ST_IDLE     = NST'(1) << 0,
    ST_RED_A    = NST'(1) << 1,
    ST_RED_B    = NST'(1) << 2,
    ST_RED_PX   = NST'(1) << 3,
    ST_RED_PY   = NST'(1) << 4,
    ST_RED_QX   = NST'(1) << 5,
    ST_RED_QY   = NST'(1) << 6,
    ST_RED_27   = NST'(1) << 7,
    ST_DISC_AA  = NST'(1) << 8,
    ST_DISC_AAA = NST'(1) << 9,
    ST_DISC_2A  = NST'(1) << 10,
    ST_DISC_4A  = NST'(1) << 11,
    ST_DISC_BB  = NST'(1) << 12,
    ST_DISC_27B = NST'(1) << 13,
    ST_DISC_SUM = NST'(1) << 14,
    ST_DISPATCH = NST'(1) << 15,
    ST_SM_LOOP  = NST'(1) << 16,
    ST_SM_DBL   = NST'(1) << 17,
    ST_ONC_YY   = NST'(1) << 18,
    ST_ONC_XX   = NST'(1) << 19,
    ST_ONC_XXX  = NST'(1) << 20,
    ST_ONC_AX   = NST'(1) << 21,
    ST_ONC_S1   = NST'(1) << 22,
    ST_ONC_S2   = NST'(1) << 23,
    ST_PA_START = NST'(1) << 24,
    ST_PA_SQ    = NST'(1) << 25,
    ST_PA_N1    = NST'(1) << 26,
    ST_PA_N2    = NST'(1) << 27,
    ST_PA_N3    = NST'(1) << 28,
    ST_PA_D2    = NST'(1) << 29,
    ST_PA_NS    = NST'(1) << 30,
    ST_PA_DS    = NST'(1) << 31,
    ST_INV_LOOP = NST'(1) << 32,
    ST_INV_DIV  = NST'(1) << 33,
    ST_INV_QT   = NST'(1) << 34,
    ST_INV_T2   = NST'(1) << 35,
    ST_PA_LAM   = NST'(1) << 36,
    ST_PA_X1    = NST'(1) << 37,
    ST_PA_X2    = NST'(1) << 38,
    ST_PA_X3    = NST'(1) << 39,
    ST_PA_Y1    = NST'(1) << 40,
    ST_PA_Y2    = NST'(1) << 41,
    ST_PA_Y3    = NST'(1) << 42,
    ST_PA_RET   = NST'(1) << 43,
    ST_FINISH   = NST'(1) << 44
  } state_t;

  // who gets the point-add result
  typedef enum logic [1:0] {
    RET_ACC = 2'd0,
    RET_DBL = 2'd1,
    RET_ONE = 2'd2
  } ret_t;

  state_t state;
  ret_t ret;
  logic issued;
  logic out_valid;
  result_t out_reg;

  logic [63:0] coef_a, coef_b, prime_modulus;

  fe_t p, ca, cb, px, py, qx, qy;
  logic pinf, qinf;
  fe_t rx, ry, dx, dy, ux, uy, vx, vy, wx, wy;
  logic rinf, dinf, uinf, vinf, winf;
  fe_t num, lam, x3, tt, inv;
  fe_t r0, r1, r2, t0, t1, eq, tm;
  logic [1:0] mode;
  logic [63:0] k;
  logic fail, on, cvalid;

  logic op_req, start, done;
  unit_op_t uop;
  fe_t opa, opb, ures, uquo;
  fe_t cfg_p;

  assign cfg_ready = 1'b1;
  assign item_stall = (state != ST_IDLE);
  assign result_valid = out_valid;
  assign result = out_reg;
  assign start = op_req && !issued;
  assign cfg_p = prime_modulus[FW-1:0];

  // operand selection for the shared unit
  always_comb begin
    op_req = 1'b1;
    uop = OP_ADD;
    opa = '0;
    opb = '0;
    case (state)
      ST_RED_A:    begin uop = OP_DIV; opa = coef_a[FW-1:0]; opb = p; end
      ST_RED_B:    begin uop = OP_DIV; opa = coef_b[FW-1:0]; opb = p; end
      ST_RED_PX:   begin uop = OP_DIV; opa = px; opb = p; end
      ST_RED_PY:   begin uop = OP_DIV; opa = py; opb = p; end
      ST_RED_QX:   begin uop = OP_DIV; opa = qx; opb = p; end
      ST_RED_QY:   begin uop = OP_DIV; opa = qy; opb = p; end
      ST_RED_27:   begin uop = OP_DIV; opa = FW'(27); opb = p; end
      ST_DISC_AA:  begin uop = OP_MUL; opa = ca; opb = ca; end
      ST_DISC_AAA: begin uop = OP_MUL; opa = num; opb = ca; end
      ST_DISC_2A:  begin uop = OP_ADD; opa = num; opb = num; end
      ST_DISC_4A:  begin uop = OP_ADD; opa = num; opb = num; end
      ST_DISC_BB:  begin uop = OP_MUL; opa = cb; opb = cb; end
      ST_DISC_27B: begin uop = OP_MUL; opa = x3; opb = lam; end
      ST_DISC_SUM: begin uop = OP_ADD; opa = num; opb = lam; end
      ST_ONC_YY:   begin uop = OP_MUL; opa = py; opb = py; end
      ST_ONC_XX:   begin uop = OP_MUL; opa = px; opb = px; end
      ST_ONC_XXX:  begin uop = OP_MUL; opa = lam; opb = px; end
      ST_ONC_AX:   begin uop = OP_MUL; opa = ca; opb = px; end
      ST_ONC_S1:   begin uop = OP_ADD; opa = lam; opb = x3; end
      ST_ONC_S2:   begin uop = OP_ADD; opa = lam; opb = cb; end
      ST_PA_SQ:    begin uop = OP_MUL; opa = ux; opb = ux; end
      ST_PA_N1:    begin uop = OP_ADD; opa = tt; opb = tt; end
      ST_PA_N2:    begin uop = OP_ADD; opa = num; opb = tt; end
      ST_PA_N3:    begin uop = OP_ADD; opa = num; opb = ca; end
      ST_PA_D2:    begin uop = OP_ADD; opa = uy; opb = uy; end
      ST_PA_NS:    begin uop = OP_SUB; opa = vy; opb = uy; end
      ST_PA_DS:    begin uop = OP_SUB; opa = vx; opb = ux; end
      ST_INV_DIV:  begin uop = OP_DIV; opa = r0; opb = r1; end
      ST_INV_QT:   begin uop = OP_MUL; opa = t1; opb = eq; end
      ST_INV_T2:   begin uop = OP_SUB; opa = t0; opb = tm; end
      ST_PA_LAM:   begin uop = OP_MUL; opa = num; opb = inv; end
      ST_PA_X1:    begin uop = OP_MUL; opa = lam; opb = lam; end
      ST_PA_X2:    begin uop = OP_SUB; opa = x3; opb = ux; end
      ST_PA_X3:    begin uop = OP_SUB; opa = x3; opb = vx; end
      ST_PA_Y1:    begin uop = OP_SUB; opa = ux; opb = x3; end
      ST_PA_Y2:    begin uop = OP_MUL; opa = lam; opb = tt; end
      ST_PA_Y3:    begin uop = OP_SUB; opa = tt; opb = uy; end
      default:     op_req = 1'b0;
    endcase
  end

  ecpo_unit u_unit (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .op      (uop),
    .a       (opa),
    .b       (opb),
    .modulus (p),
    .done    (done),
    .res     (ures),
    .quo     (uquo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      issued <= 1'b0;
      out_valid <= 1'b0;
      coef_a <= COEF_A_RST;
      coef_b <= COEF_B_RST;
      prime_modulus <= PRIME_RST;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_COEF_A: coef_a <= cfg_data;
          CFG_COEF_B: coef_b <= cfg_data;
          CFG_PRIME:  prime_modulus <= cfg_data;
          default: ;
        endcase
      end

      if (start) issued <= 1'b1;
      else if (done) issued <= 1'b0;

      // result transaction taken
      if (out_valid && !result_stall) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            p <= (cfg_p < FW'(2)) ? FW'(1) : cfg_p;
            mode <= item.mode;
            px <= item.first_x[FW-1:0];
            py <= item.first_y[FW-1:0];
            pinf <= item.first_at_infinity;
            qx <= item.second_x[FW-1:0];
            qy <= item.second_y[FW-1:0];
            qinf <= item.second_at_infinity;
            k <= item.scalar;
            rx <= '0;
            ry <= '0;
            rinf <= 1'b0;
            fail <= 1'b0;
            on <= 1'b0;
            state <= ST_RED_A;
          end
        end
        // reduction of operands
        ST_RED_A:  if (done) begin ca <= ures; state <= ST_RED_B; end
        ST_RED_B:  if (done) begin cb <= ures; state <= ST_RED_PX; end
        ST_RED_PX: if (done) begin px <= ures; state <= ST_RED_PY; end
        ST_RED_PY: if (done) begin py <= ures; state <= ST_RED_QX; end
        ST_RED_QX: if (done) begin qx <= ures; state <= ST_RED_QY; end
        ST_RED_QY: if (done) begin qy <= ures; state <= ST_RED_27; end
        ST_RED_27: if (done) begin x3 <= ures; state <= ST_DISC_AA; end
        // discriminant
        ST_DISC_AA:  if (done) begin num <= ures; state <= ST_DISC_AAA; end
        ST_DISC_AAA: if (done) begin num <= ures; state <= ST_DISC_2A; end
        ST_DISC_2A:  if (done) begin num <= ures; state <= ST_DISC_4A; end
        ST_DISC_4A:  if (done) begin num <= ures; state <= ST_DISC_BB; end
        ST_DISC_BB:  if (done) begin lam <= ures; state <= ST_DISC_27B; end
        ST_DISC_27B: if (done) begin lam <= ures; state <= ST_DISC_SUM; end
        ST_DISC_SUM: if (done) begin cvalid <= (ures != '0); state <= ST_DISPATCH; end
        ST_DISPATCH: begin
          if (mode == MODE_MUL) begin
            rinf <= 1'b1;
            dx <= px;
            dy <= py;
            dinf <= pinf;
            state <= ST_SM_LOOP;
          end else if (mode == MODE_ADD) begin
            ux <= px; uy <= py; uinf <= pinf;
            vx <= qx; vy <= qy; vinf <= qinf;
            ret <= RET_ONE;
            state <= ST_PA_START;
          end else if (pinf) begin
            on <= 1'b1;
            state <= ST_FINISH;
          end else begin
            state <= ST_ONC_YY;
          end
        end
        // double-and-add over the scalar bits
        ST_SM_LOOP: begin
          if (k == '0) begin
            state <= ST_FINISH;
          end else if (k[0]) begin
            ux <= rx; uy <= ry; uinf <= rinf;
            vx <= dx; vy <= dy; vinf <= dinf;
            ret <= RET_ACC;
            state <= ST_PA_START;
          end else begin
            state <= ST_SM_DBL;
          end
        end
        ST_SM_DBL: begin
          ux <= dx; uy <= dy; uinf <= dinf;
          vx <= dx; vy <= dy; vinf <= dinf;
          ret <= RET_DBL;
          state <= ST_PA_START;
        end
        // on-curve test
        ST_ONC_YY:  if (done) begin num <= ures; state <= ST_ONC_XX; end
        ST_ONC_XX:  if (done) begin lam <= ures; state <= ST_ONC_XXX; end
        ST_ONC_XXX: if (done) begin lam <= ures; state <= ST_ONC_AX; end
        ST_ONC_AX:  if (done) begin x3 <= ures; state <= ST_ONC_S1; end
        ST_ONC_S1:  if (done) begin lam <= ures; state <= ST_ONC_S2; end
        ST_ONC_S2:  if (done) begin on <= (num == ures); state <= ST_FINISH; end
        // point add: special cases
        ST_PA_START: begin
          if (uinf) begin
            wx <= vx; wy <= vy; winf <= vinf;
            state <= ST_PA_RET;
          end else if (vinf) begin
            wx <= ux; wy <= uy; winf <= uinf;
            state <= ST_PA_RET;
          end else if (ux == vx && (uy != vy || uy == '0)) begin
            wx <= '0; wy <= '0; winf <= 1'b1;
            state <= ST_PA_RET;
          end else if (ux == vx) begin
            state <= ST_PA_SQ;
          end else begin
            state <= ST_PA_NS;
          end
        end
        // slope numerator and denominator
        ST_PA_SQ: if (done) begin tt <= ures; state <= ST_PA_N1; end
        ST_PA_N1: if (done) begin num <= ures; state <= ST_PA_N2; end
        ST_PA_N2: if (done) begin num <= ures; state <= ST_PA_N3; end
        ST_PA_N3: if (done) begin num <= ures; state <= ST_PA_D2; end
        ST_PA_NS: if (done) begin num <= ures; state <= ST_PA_DS; end
        ST_PA_D2, ST_PA_DS: begin
          if (done) begin
            r0 <= p;
            r1 <= ures;
            t0 <= '0;
            t1 <= (p == FW'(1)) ? '0 : FW'(1);
            state <= ST_INV_LOOP;
          end
        end
        // extended euclid inverse
        ST_INV_LOOP: begin
          if (r1 == '0) begin
            if (r0 != FW'(1)) begin
              fail <= 1'b1;
              inv <= '0;
            end else begin
              inv <= t0;
            end
            state <= ST_PA_LAM;
          end else begin
            state <= ST_INV_DIV;
          end
        end
        ST_INV_DIV: if (done) begin r2 <= ures; eq <= uquo; state <= ST_INV_QT; end
        ST_INV_QT:  if (done) begin tm <= ures; state <= ST_INV_T2; end
        ST_INV_T2: begin
          if (done) begin
            r0 <= r1;
            r1 <= r2;
            t0 <= t1;
            t1 <= ures;
            state <= ST_INV_LOOP;
          end
        end
        // new point from the slope
        ST_PA_LAM: if (done) begin lam <= ures; state <= ST_PA_X1; end
        ST_PA_X1:  if (done) begin x3 <= ures; state <= ST_PA_X2; end
        ST_PA_X2:  if (done) begin x3 <= ures; state <= ST_PA_X3; end
        ST_PA_X3:  if (done) begin x3 <= ures; state <= ST_PA_Y1; end
        ST_PA_Y1:  if (done) begin tt <= ures; state <= ST_PA_Y2; end
        ST_PA_Y2:  if (done) begin tt <= ures; state <= ST_PA_Y3; end
        ST_PA_Y3: begin
          if (done) begin
            wx <= x3;
            wy <= ures;
            winf <= 1'b0;
            state <= ST_PA_RET;
          end
        end
        ST_PA_RET: begin
          case (ret)
            RET_ACC: begin
              rx <= wx; ry <= wy; rinf <= winf;
              state <= ST_SM_DBL;
            end
            RET_DBL: begin
              dx <= wx; dy <= wy; dinf <= winf;
              k <= k >> 1;
              state <= ST_SM_LOOP;
            end
            default: begin
              rx <= wx; ry <= wy; rinf <= winf;
              state <= ST_FINISH;
            end
          endcase
        end
        // load the output register once it is free
        ST_FINISH: begin
          if (!out_valid) begin
            out_reg.result_x <= rinf ? 64'd0 : 64'(rx);
            out_reg.result_y <= rinf ? 64'd0 : 64'(ry);
            out_reg.result_at_infinity <= rinf;
            out_reg.on_curve <= on;
            out_reg.curve_valid <= cvalid;
            out_reg.no_inverse <= fail;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ecpo_unit.sv */
`default_nettype none

module ecpo_unit import ecpo_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  unit_op_t op,
  input  fe_t      a,
  input  fe_t      b,
  input  fe_t      modulus,
  output logic     done,
  output fe_t      res,
  output fe_t      quo
);

  typedef enum logic [3:0] {
    U_IDLE  = 4'b0001,
    U_MUL   = 4'b0010,
    U_ALIGN = 4'b0100,
    U_DIV   = 4'b1000
  } ustate_t;

  ustate_t ust;
  fe_t acc, mx, my;
  fe_t rem, dv, q;
  logic [CW-1:0] cnt;

  logic rem_ge;
  fe_t rem_n, q_n;
  logic can_shift;

  // one restoring division step
  always_comb begin
    rem_ge = rem >= dv;
    rem_n = rem_ge ? (rem - dv) : rem;
    q_n = {q[FW-2:0], rem_ge};
    can_shift = !dv[FW-1] && ({dv, 1'b0} <= {1'b0, rem});
  end

  // add/sub straight from idle, lsb-first multiply, aligned long division
  always_ff @(posedge clk) begin
    if (rst) begin
      ust <= U_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (ust)
        U_IDLE: begin
          if (start) begin
            case (op)
              OP_ADD: begin
                res <= m_add(a, b, modulus);
                done <= 1'b1;
              end
              OP_SUB: begin
                res <= m_sub(a, b, modulus);
                done <= 1'b1;
              end
              OP_MUL: begin
                acc <= '0;
                mx <= a;
                my <= b;
                ust <= U_MUL;
              end
              OP_DIV: begin
                rem <= a;
                dv <= b;
                q <= '0;
                cnt <= '0;
                ust <= U_ALIGN;
              end
            endcase
          end
        end
        U_MUL: begin
          if (my == '0) begin
            res <= acc;
            done <= 1'b1;
            ust <= U_IDLE;
          end else begin
            if (my[0]) acc <= m_add(acc, mx, modulus);
            mx <= m_add(mx, mx, modulus);
            my <= my >> 1;
          end
        end
        U_ALIGN: begin
          if (can_shift) begin
            dv <= dv << 1;
            cnt <= cnt + 1'b1;
          end else begin
            ust <= U_DIV;
          end
        end
        U_DIV: begin
          rem <= rem_n;
          q <= q_n;
          dv <= dv >> 1;
          if (cnt == '0) begin
            res <= rem_n;
            // a quotient equal to the modulus reduces to zero
            quo <= (q_n == modulus) ? '0 : q_n;
            done <= 1'b1;
            ust <= U_IDLE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: ust <= U_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ecpo_checker.sv */
`default_nettype none

module ecpo_checker import ecpo_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // an accepted item keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("block not busy after input transaction");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // point at infinity reads as zero coordinates
  a_inf_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_at_infinity |->
      result.result_x == 64'd0 && result.result_y == 64'd0)
    else $error("infinity result with nonzero coordinates");

  // an on-curve answer carries an empty point and no inverse failure
  a_check_pt: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.on_curve |->
      !result.result_at_infinity && !result.no_inverse &&
      result.result_x == 64'd0 && result.result_y == 64'd0)
    else $error("on-curve result with point fields set");

endmodule

bind ec_prime_field_point_ops ecpo_checker u_ecpo_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
